@@ hw/rtl/las_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// las_pkg
// Shared types, constants and helpers of the linear ADSR envelope.
// ----------------------------------------------------------------------------
package las_pkg;

  // gain and slope: signed, 32 fraction bits
  localparam int GAIN_W = 40;
  localparam int FRAC_W = 32;
  localparam logic [GAIN_W-1:0] ONE_Q32 = 40'h01_0000_0000;

  // output gain, unsigned Q1.16
  localparam int G16_W = 17;
  localparam logic [G16_W-1:0] G16_ONE = 17'h1_0000;

  // sustain level register width
  localparam int SUS_W = 17;

  // serial step counts
  localparam int MUL_STEPS = G16_W;
  localparam int MUL_CNT_W = $clog2(MUL_STEPS + 1);
  localparam int DIV_STEPS = GAIN_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

  // input opcodes
  localparam logic [1:0] OP_TICK     = 2'd0;
  localparam logic [1:0] OP_GATE_ON  = 2'd1;
  localparam logic [1:0] OP_GATE_OFF = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_ATTACK  = 2'd0;
  localparam logic [1:0] CFG_DECAY   = 2'd1;
  localparam logic [1:0] CFG_SUSTAIN = 2'd2;
  localparam logic [1:0] CFG_RELEASE = 2'd3;

  // start request for the serial multiplier
  typedef struct packed {
    logic             start;
    logic [G16_W-1:0] gain;
  } las_mul_req_t;

  // start request for the serial divider (magnitude and sign of numerator)
  typedef struct packed {
    logic              start;
    logic              neg;
    logic [GAIN_W-1:0] mag;
  } las_div_req_t;

  // clamp gain to 0..1 and round to Q1.16
  function automatic logic [G16_W-1:0] gain_q16(input logic [GAIN_W-1:0] g);
    logic [G16_W-1:0] r;
    if (g[GAIN_W-1]) begin
      r = '0;
    end else if (g > ONE_Q32) begin
      r = G16_ONE;
    end else begin
      r = g[FRAC_W:FRAC_W-G16_W+1] + G16_W'(g[FRAC_W-G16_W]);
    end
    return r;
  endfunction

endpackage

@@ hw/rtl/las_mul.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// las_mul
// Bit-serial signed sample times unsigned Q1.16 gain, one gain bit per cycle,
// result rounded to nearest with ties toward plus infinity.
// ----------------------------------------------------------------------------
module las_mul import las_pkg::*; #(
  parameter int SampleW = 24
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  las_mul_req_t       req_i,
  input  logic [SampleW-1:0] sample_i,
  output logic               done_o,
  output logic [SampleW-1:0] result_o
);

  logic                 busy_q, busy_d;
  logic [MUL_CNT_W-1:0] cnt_q, cnt_d;
  logic [SampleW-1:0]   smp_q;
  logic [G16_W-1:0]     mplr_q;
  logic [SampleW-1:0]   hi_q;
  logic [G16_W-1:0]     lo_q;
  logic [SampleW:0]     sum;
  logic                 step;

  assign step   = busy_q && (cnt_q != '0);
  assign done_o = busy_q && (cnt_q == '0);

  // add multiplicand on a set gain bit, then shift product right
  always_comb begin
    sum = {hi_q[SampleW-1], hi_q};
    if (mplr_q[0]) begin
      sum = sum + {smp_q[SampleW-1], smp_q};
    end
  end

  // control
  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = MUL_CNT_W'(MUL_STEPS);
    end else if (step) begin
      cnt_d = cnt_q - MUL_CNT_W'(1);
    end else if (done_o) begin
      busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath shift registers
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      smp_q  <= sample_i;
      mplr_q <= req_i.gain;
      hi_q   <= '0;
      lo_q   <= '0;
    end else if (step) begin
      mplr_q <= {1'b0, mplr_q[G16_W-1:1]};
      hi_q   <= sum[SampleW:1];
      lo_q   <= {sum[0], lo_q[G16_W-1:1]};
    end
  end

  // product shifted down 16 bits, plus the rounding bit
  assign result_o = {hi_q[SampleW-2:0], lo_q[G16_W-1]} + SampleW'(lo_q[G16_W-2]);

endmodule

@@ hw/rtl/las_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// las_div
// Restoring divider, one quotient bit per cycle; quotient truncated toward
// zero and returned as a signed slope.
// ----------------------------------------------------------------------------
module las_div import las_pkg::*; #(
  parameter int DenW = 21
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  las_div_req_t      req_i,
  input  logic [DenW-1:0]   den_i,
  output logic              done_o,
  output logic [GAIN_W-1:0] quot_o
);

  logic                 busy_q, busy_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [DenW-1:0]      rem_q;
  logic [DenW-1:0]      den_q;
  logic [GAIN_W-1:0]    num_q;
  logic                 neg_q;
  logic [DenW:0]        trial;
  logic [DenW:0]        diff;
  logic                 fits;
  logic                 step;

  assign step   = busy_q && (cnt_q != '0);
  assign done_o = busy_q && (cnt_q == '0);

  // trial subtraction of the divisor
  always_comb begin
    trial = {rem_q, num_q[GAIN_W-1]};
    diff  = trial - {1'b0, den_q};
    fits  = trial >= {1'b0, den_q};
  end

  // control
  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = DIV_CNT_W'(DIV_STEPS);
    end else if (step) begin
      cnt_d = cnt_q - DIV_CNT_W'(1);
    end else if (done_o) begin
      busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  // numerator shifts out at the top while quotient bits shift in below
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      num_q <= req_i.mag;
      den_q <= den_i;
      neg_q <= req_i.neg;
    end else if (step) begin
      rem_q <= fits ? diff[DenW-1:0] : trial[DenW-1:0];
      num_q <= {num_q[GAIN_W-2:0], fits};
    end
  end

  assign quot_o = neg_q ? (~num_q + GAIN_W'(1)) : num_q;

endmodule

@@ hw/rtl/linear_adsr_envelope.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_adsr_envelope
// Linear attack/decay/sustain/release amplitude envelope with a bit-serial
// sample multiplier and a bit-serial slope divider.
// ----------------------------------------------------------------------------
// channel   dir  handshake                    content
// s_axis    in   s_axis_tvalid/s_axis_tready  tdata: sample_in, tuser: opcode
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata: sample_out, gain_now, is_off
// cfg       in   cfg_we_i                     cfg_idx_i, cfg_wdata_i
//
// a sample tick runs the serial multiplier, then advances the envelope; a
// tick that ends the attack also runs the serial divider for the decay
// slope. gate events run the 40-step divider for the new slope. one
// transaction is worked on at a time; a finished result waits in the output
// register while the next transaction is taken. reset puts the envelope in
// the off phase with zero gain.
// ----------------------------------------------------------------------------
module linear_adsr_envelope import las_pkg::*; #(
  parameter int SAMPLE_BITS = 24,
  parameter int COUNT_BITS  = 20,
  localparam int InDataW  = ((SAMPLE_BITS + 7) / 8) * 8,
  localparam int OutDataW = ((SAMPLE_BITS + G16_W + 1 + 7) / 8) * 8,
  localparam int CfgW     = (COUNT_BITS > SUS_W) ? COUNT_BITS : SUS_W
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // input stream
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,   // sample_in
  input  logic [1:0]          s_axis_tuser,   // opcode
  // output stream
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,   // sample_out, gain_now, is_off
  // configuration writes
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [CfgW-1:0]     cfg_wdata_i
);

  localparam int LenW = COUNT_BITS + 1;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL  = 5'b00010,
    ST_ADV  = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_OUT  = 5'b10000
  } state_e;

  typedef enum logic [4:0] {
    PH_OFF     = 5'b00001,
    PH_ATTACK  = 5'b00010,
    PH_DECAY   = 5'b00100,
    PH_SUSTAIN = 5'b01000,
    PH_RELEASE = 5'b10000
  } phase_e;

  // configuration registers
  logic [COUNT_BITS-1:0] attack_q, decay_q, release_q;
  logic [SUS_W-1:0]      sustain_q;

  // envelope state
  state_e            st_q, st_d;
  phase_e            phase_q, phase_d;
  logic [LenW-1:0]   elapsed_q, elapsed_d;
  logic [LenW-1:0]   len_q, len_d;
  logic [GAIN_W-1:0] gain_q, gain_d;
  logic [GAIN_W-1:0] slope_q, slope_d;

  // per-transaction registers
  logic [1:0]             op_q, op_d;
  logic [G16_W-1:0]       g16_q, g16_d;
  logic [SAMPLE_BITS-1:0] samp_q, samp_d;
  logic                   add_after_q, add_after_d;

  // output register
  logic                   m_valid_q;
  logic [SAMPLE_BITS-1:0] sample_out_q;
  logic [G16_W-1:0]       gain_now_q;
  logic                   is_off_q;
  logic                   out_load;

  // serial units
  las_mul_req_t           mul_req;
  logic                   mul_done;
  logic [SAMPLE_BITS-1:0] mul_result;
  las_div_req_t           div_req;
  logic [LenW-1:0]        div_den;
  logic                   div_done;
  logic [GAIN_W-1:0]      div_quot;

  logic              in_fire;
  logic [G16_W-1:0]  gain_now;
  logic [LenW-1:0]   attack_len, decay_len, release_len;
  logic [LenW-1:0]   elapsed_inc;
  logic [GAIN_W-1:0] sus_gain, decay_num, gain_mag;

  assign s_axis_tready = (st_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  assign gain_now    = gain_q16(gain_q);
  assign attack_len  = {1'b0, attack_q} + LenW'(1);
  assign decay_len   = {1'b0, decay_q} + LenW'(1);
  assign release_len = {1'b0, release_q} + LenW'(1);
  assign elapsed_inc = elapsed_q + LenW'(1);
  assign sus_gain    = {{(GAIN_W-SUS_W-16){1'b0}}, sustain_q, 16'h0000};
  assign decay_num   = sus_gain - ONE_Q32;
  assign gain_mag    = gain_q[GAIN_W-1] ? (~gain_q + GAIN_W'(1)) : gain_q;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attack_q  <= '0;
      decay_q   <= '0;
      sustain_q <= G16_ONE;
      release_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ATTACK:  attack_q  <= cfg_wdata_i[COUNT_BITS-1:0];
        CFG_DECAY:   decay_q   <= cfg_wdata_i[COUNT_BITS-1:0];
        CFG_SUSTAIN: sustain_q <= cfg_wdata_i[SUS_W-1:0];
        CFG_RELEASE: release_q <= cfg_wdata_i[COUNT_BITS-1:0];
        default:     attack_q  <= attack_q;
      endcase
    end
  end

  // sequencer and envelope update
  always_comb begin
    st_d        = st_q;
    phase_d     = phase_q;
    elapsed_d   = elapsed_q;
    len_d       = len_q;
    gain_d      = gain_q;
    slope_d     = slope_q;
    op_d        = op_q;
    g16_d       = g16_q;
    samp_d      = samp_q;
    add_after_d = add_after_q;
    out_load    = 1'b0;

    mul_req.start = 1'b0;
    mul_req.gain  = gain_now;
    div_req.start = 1'b0;
    div_req.neg   = 1'b0;
    div_req.mag   = ONE_Q32;
    div_den       = attack_len;

    unique case (st_q)
      ST_IDLE: begin
        if (in_fire) begin
          op_d        = s_axis_tuser;
          add_after_d = 1'b0;
          case (s_axis_tuser)
            OP_TICK: begin
              g16_d         = gain_now;
              mul_req.start = 1'b1;
              st_d          = ST_MUL;
            end
            OP_GATE_ON: begin
              phase_d       = PH_ATTACK;
              elapsed_d     = '0;
              len_d         = attack_len;
              gain_d        = '0;
              div_req.start = 1'b1;
              st_d          = ST_DIV;
            end
            OP_GATE_OFF: begin
              phase_d       = PH_RELEASE;
              elapsed_d     = '0;
              len_d         = release_len;
              div_req.start = 1'b1;
              div_req.neg   = ~gain_q[GAIN_W-1];
              div_req.mag   = gain_mag;
              div_den       = release_len;
              st_d          = ST_DIV;
            end
            default: st_d = ST_OUT;
          endcase
        end
      end
      ST_MUL: begin
        if (mul_done) begin
          samp_d = mul_result;
          st_d   = ST_ADV;
        end
      end
      ST_ADV: begin
        st_d = ST_OUT;
        if (phase_q != PH_OFF && phase_q != PH_SUSTAIN) begin
          if (elapsed_inc >= len_q) begin
            elapsed_d = '0;
            unique case (phase_q)
              PH_ATTACK: begin
                // decay starts from one, slope follows from the divider
                phase_d       = PH_DECAY;
                len_d         = decay_len;
                gain_d        = ONE_Q32;
                div_req.start = 1'b1;
                div_req.neg   = decay_num[GAIN_W-1];
                div_req.mag   = decay_num[GAIN_W-1] ? (~decay_num + GAIN_W'(1))
                                                     : decay_num;
                div_den       = decay_len;
                add_after_d   = 1'b1;
                st_d          = ST_DIV;
              end
              PH_DECAY: begin
                phase_d = PH_SUSTAIN;
                len_d   = LenW'(1);
                gain_d  = sus_gain;
                slope_d = '0;
              end
              default: begin
                phase_d = PH_OFF;
                len_d   = LenW'(1);
                gain_d  = '0;
                slope_d = '0;
              end
            endcase
          end else begin
            elapsed_d = elapsed_inc;
            gain_d    = gain_q + slope_q;
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          slope_d = div_quot;
          if (add_after_q) begin
            gain_d = gain_q + div_quot;
          end
          st_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!m_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          st_d     = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      phase_q     <= PH_OFF;
      elapsed_q   <= '0;
      len_q       <= LenW'(1);
      gain_q      <= '0;
      slope_q     <= '0;
      op_q        <= OP_TICK;
      add_after_q <= 1'b0;
      m_valid_q   <= 1'b0;
    end else begin
      st_q        <= st_d;
      phase_q     <= phase_d;
      elapsed_q   <= elapsed_d;
      len_q       <= len_d;
      gain_q      <= gain_d;
      slope_q     <= slope_d;
      op_q        <= op_d;
      add_after_q <= add_after_d;
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    g16_q  <= g16_d;
    samp_q <= samp_d;
    if (out_load) begin
      sample_out_q <= (op_q == OP_TICK) ? samp_q : '0;
      gain_now_q   <= (op_q == OP_TICK) ? g16_q : gain_now;
      is_off_q     <= (phase_q == PH_OFF);
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = OutDataW'({is_off_q, gain_now_q, sample_out_q});

  // serial sample multiplier
  las_mul #(
    .SampleW (SAMPLE_BITS)
  ) u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (mul_req),
    .sample_i (s_axis_tdata[SAMPLE_BITS-1:0]),
    .done_o   (mul_done),
    .result_o (mul_result)
  );

  // serial slope divider
  las_div #(
    .DenW (LenW)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .den_i  (div_den),
    .done_o (div_done),
    .quot_o (div_quot)
  );

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the linear ADSR envelope. A directed table and then
// random note sequences drive the input stream under several register
// settings. An in-bench envelope predictor computes the expected output
// transaction for every accepted input, and the output stream is checked
// field by field in order under random backpressure.
// ----------------------------------------------------------------------------
module tb import las_pkg::*; ();

  localparam int SAMPLE_W          = 24;
  localparam int COUNT_W           = 20;
  localparam int SETTLE_CYCLES     = 64;
  localparam int QUIET_LIMIT       = 4000;
  localparam int NUM_SETTINGS      = 6;
  localparam int ITEMS_PER_SETTING = 170;
  localparam int RAND_ITEMS        = NUM_SETTINGS * ITEMS_PER_SETTING;
  localparam int NUM_DIR           = 34;

  // opcode with no effect
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam longint GAIN_UNITY = 64'sh1_0000_0000;

  typedef enum logic [2:0] {
    PH_OFF, PH_ATTACK, PH_DECAY, PH_SUSTAIN, PH_RELEASE
  } envelope_phase_e;

  // output transaction, sample_out in the lowest bits
  typedef struct packed {
    logic             is_off;
    logic [G16_W-1:0] gain_now;
    logic [23:0]      sample_out;
  } env_result_t;

  // directed row: an input transaction or a register write
  typedef struct packed {
    logic        is_cfg;
    logic [1:0]  code;
    logic [23:0] value;
    logic        typed;
    env_result_t want;
  } dir_row_t;

  localparam dir_row_t DIR_ROWS [NUM_DIR] = '{
    // reset settings: off phase, tick, unused opcode, release from off
    '{1'b0, OP_TICK,     24'h7F_FFFF, 1'b1, '{1'b1, 17'h0, 24'h0}},
    '{1'b0, OP_UNUSED,   24'h12_3456, 1'b1, '{1'b1, 17'h0, 24'h0}},
    '{1'b0, OP_GATE_OFF, 24'h00_0000, 1'b1, '{1'b0, 17'h0, 24'h0}},
    '{1'b0, OP_TICK,     24'h7F_FFFF, 1'b1, '{1'b1, 17'h0, 24'h0}},
    // one-tick attack and decay, full scale samples at unity gain
    '{1'b0, OP_GATE_ON,  24'h00_0000, 1'b1, '{1'b0, 17'h0, 24'h0}},
    '{1'b0, OP_TICK,     24'h7F_FFFF, 1'b1, '{1'b0, 17'h0, 24'h0}},
    '{1'b0, OP_TICK,     24'h7F_FFFF, 1'b1, '{1'b0, G16_ONE, 24'h7F_FFFF}},
    '{1'b0, OP_TICK,     24'h80_0000, 1'b1, '{1'b0, G16_ONE, 24'h80_0000}},
    '{1'b0, OP_TICK,     24'hFF_FFFF, 1'b1, '{1'b0, G16_ONE, 24'hFF_FFFF}},
    '{1'b0, OP_GATE_OFF, 24'h00_0000, 1'b1, '{1'b0, G16_ONE, 24'h0}},
    '{1'b0, OP_TICK,     24'h00_0001, 1'b1, '{1'b1, G16_ONE, 24'h00_0001}},
    // short phases, half sustain
    '{1'b1, CFG_ATTACK,  24'h00_0002, 1'b0, '0},
    '{1'b1, CFG_DECAY,   24'h00_0002, 1'b0, '0},
    '{1'b1, CFG_SUSTAIN, 24'h00_8000, 1'b0, '0},
    '{1'b1, CFG_RELEASE, 24'h00_0002, 1'b0, '0},
    '{1'b0, OP_GATE_ON,  24'h00_0000, 1'b0, '0},
    '{1'b0, OP_TICK,     24'h40_0000, 1'b0, '0},
    '{1'b0, OP_TICK,     24'h7F_FFFF, 1'b0, '0},
    '{1'b0, OP_TICK,     24'h80_0000, 1'b0, '0},
    '{1'b0, OP_TICK,     24'h7F_FFFF, 1'b0, '0},
    // retrigger in decay, then release straight from attack
    '{1'b0, OP_GATE_ON,  24'hAA_AAAA, 1'b0, '0},
    '{1'b0, OP_TICK,     24'h55_5555, 1'b0, '0},
    '{1'b0, OP_GATE_OFF, 24'h00_0000, 1'b0, '0},
    '{1'b0, OP_TICK,     24'h7F_FFFF, 1'b0, '0},
    // sustain above one, written with extra upper bits
    '{1'b1, CFG_SUSTAIN, 24'h0F_FFFF, 1'b0, '0},
    '{1'b1, CFG_ATTACK,  24'h00_0000, 1'b0, '0},
    '{1'b1, CFG_DECAY,   24'h00_0003, 1'b0, '0},
    '{1'b0, OP_GATE_ON,  24'h00_0000, 1'b0, '0},
    '{1'b0, OP_TICK,     24'h7F_FFFF, 1'b0, '0},
    '{1'b0, OP_TICK,     24'h7F_FFFF, 1'b0, '0},
    '{1'b0, OP_TICK,     24'h7F_FFFF, 1'b0, '0},
    '{1'b0, OP_TICK,     24'h80_0000, 1'b0, '0},
    '{1'b0, OP_GATE_OFF, 24'h00_0000, 1'b0, '0},
    '{1'b0, OP_UNUSED,   24'h7F_FFFF, 1'b0, '0}
  };

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [23:0]        s_axis_tdata  = '0;  // sample_in
  logic [1:0]         s_axis_tuser  = '0;  // opcode
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [47:0]        m_axis_tdata;        // sample_out, gain_now, is_off
  logic               cfg_we_i      = 1'b0;
  logic [1:0]         cfg_idx_i     = '0;
  logic [COUNT_W-1:0] cfg_wdata_i   = '0;

  // predictor state and its copy of the registers
  envelope_phase_e    env_phase   = PH_OFF;
  longint             env_elapsed = 0;
  longint             env_len     = 1;
  longint             env_gain    = 0;
  longint             env_slope   = 0;
  logic [COUNT_W-1:0] attack_cfg  = '0;
  logic [COUNT_W-1:0] decay_cfg   = '0;
  logic [COUNT_W-1:0] release_cfg = '0;
  logic [SUS_W-1:0]   sustain_cfg = 17'h1_0000;

  env_result_t pending_results[$];
  int          mismatch_cnt  = 0;
  int          rand_items    = 0;
  int          setting_items = 0;
  int          snd_idle      = 14;
  int          rcv_idle      = 50;

  linear_adsr_envelope #(
    .SAMPLE_BITS(SAMPLE_W),
    .COUNT_BITS (COUNT_W)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  // clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // gain clamped to 0..1, rounded to Q1.16
  function automatic logic [G16_W-1:0] clamp_gain16(input longint g);
    longint c;
    c = g;
    if (c < 0) c = 0;
    if (c > GAIN_UNITY) c = GAIN_UNITY;
    c = (c + 32768) >>> 16;
    return c[G16_W-1:0];
  endfunction

  // envelope predictor: one input transaction in, one result out
  function automatic env_result_t envelope_step(input logic [1:0] op,
                                                input logic [23:0] smp);
    env_result_t        r;
    longint             prod;
    longint             sustain_gain;
    logic signed [39:0] wrapped;
    r = '0;
    sustain_gain = longint'({sustain_cfg, 16'h0});
    case (op)
      OP_TICK: begin
        // scale by the present gain, then advance
        r.gain_now = clamp_gain16(env_gain);
        prod = longint'(signed'(smp)) * longint'(r.gain_now);
        prod = (prod + 32768) >>> 16;
        r.sample_out = prod[23:0];
        if (env_phase != PH_OFF && env_phase != PH_SUSTAIN) begin
          env_elapsed++;
          if (env_elapsed >= env_len) begin
            env_elapsed = 0;
            case (env_phase)
              PH_ATTACK: begin
                env_phase = PH_DECAY;
                env_len   = longint'(decay_cfg) + 1;
                env_gain  = GAIN_UNITY;
                env_slope = (sustain_gain - GAIN_UNITY) / env_len;
              end
              PH_DECAY: begin
                env_phase = PH_SUSTAIN;
                env_len   = 1;
                env_gain  = sustain_gain;
                env_slope = 0;
              end
              default: begin
                env_phase = PH_OFF;
                env_len   = 1;
                env_gain  = 0;
                env_slope = 0;
              end
            endcase
          end
          wrapped  = 40'(env_gain + env_slope);
          env_gain = wrapped;
        end
      end
      OP_GATE_ON: begin
        env_phase   = PH_ATTACK;
        env_elapsed = 0;
        env_len     = longint'(attack_cfg) + 1;
        env_gain    = 0;
        env_slope   = GAIN_UNITY / env_len;
        r.gain_now  = clamp_gain16(env_gain);
      end
      OP_GATE_OFF: begin
        env_phase   = PH_RELEASE;
        env_elapsed = 0;
        env_len     = longint'(release_cfg) + 1;
        env_slope   = (-env_gain) / env_len;
        r.gain_now  = clamp_gain16(env_gain);
      end
      default: begin
        r.gain_now = clamp_gain16(env_gain);
      end
    endcase
    r.is_off = (env_phase == PH_OFF);
    return r;
  endfunction

  // one input transaction; queue the typed or the predicted result
  task automatic send_item(input logic [1:0] op, input logic [23:0] smp,
                           input logic typed, input env_result_t want);
    env_result_t predicted;
    while ($urandom_range(0, 99) < snd_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= smp;
    s_axis_tuser  <= op;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predicted = envelope_step(op, smp);
    pending_results.push_back(typed ? want : predicted);
  endtask

  // hold the input until every result is back and the block has settled
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // register write; the caller lowers the write enable
  task automatic write_reg(input logic [1:0] idx, input logic [COUNT_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    case (idx)
      CFG_ATTACK:  attack_cfg  = val;
      CFG_DECAY:   decay_cfg   = val;
      CFG_SUSTAIN: sustain_cfg = val[SUS_W-1:0];
      default:     release_cfg = val;
    endcase
  endtask

  // random transaction with occasional noise and a rare full drain
  task automatic feed(input logic [1:0] op);
    logic [1:0] code;
    code = op;
    if ($urandom_range(0, 99) < 8) code = 2'($urandom_range(0, 3));
    if ($urandom_range(0, 199) == 0) wait_idle();
    if (rand_items < RAND_ITEMS / 3) begin
      snd_idle = 14;
      rcv_idle = 50;
    end else if (rand_items < 2 * RAND_ITEMS / 3) begin
      snd_idle = 50;
      rcv_idle = 14;
    end else begin
      snd_idle = 0;
      rcv_idle = 0;
    end
    send_item(code, 24'($urandom()), 1'b0, '0);
    if (code != OP_UNUSED) begin
      rand_items++;
      setting_items++;
    end
  endtask

  // output check against the oldest expectation
  always @(posedge clk_i) begin : rx_check
    env_result_t got;
    env_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[41:0];
      if (pending_results.size() == 0) begin
        $error("result with nothing expected: %0h", got);
        mismatch_cnt++;
      end else begin
        want = pending_results.pop_front();
        if (got.sample_out !== want.sample_out) begin
          $error("sample_out expected %0h actual %0h", want.sample_out, got.sample_out);
          mismatch_cnt++;
        end
        if (got.gain_now !== want.gain_now) begin
          $error("gain_now expected %0h actual %0h", want.gain_now, got.gain_now);
          mismatch_cnt++;
        end
        if (got.is_off !== want.is_off) begin
          $error("is_off expected %0h actual %0h", want.is_off, got.is_off);
          mismatch_cnt++;
        end
      end
    end
    m_axis_tready <= ($urandom_range(0, 99) >= rcv_idle);
  end

  // watchdog on cycles with no transaction on either stream
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("linear_adsr_envelope regression: fail");
    $finish;
  end

  // stimulus
  initial begin : stimulus
    logic               prev_cfg;
    logic [COUNT_W-1:0] att;
    logic [COUNT_W-1:0] dec;
    logic [COUNT_W-1:0] sus;
    logic [COUNT_W-1:0] rel;
    int                 hold;
    int                 tail;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    prev_cfg = 1'b0;
    for (int i = 0; i < NUM_DIR; i++) begin
      if (DIR_ROWS[i].is_cfg) begin
        if (!prev_cfg) wait_idle();
        write_reg(DIR_ROWS[i].code, DIR_ROWS[i].value[COUNT_W-1:0]);
      end else begin
        cfg_we_i <= 1'b0;
        send_item(DIR_ROWS[i].code, DIR_ROWS[i].value, DIR_ROWS[i].typed,
                  DIR_ROWS[i].want);
      end
      prev_cfg = DIR_ROWS[i].is_cfg;
    end

    // random note sequences under each register setting
    for (int k = 0; k < NUM_SETTINGS; k++) begin
      case (k)
        0: begin
          att = COUNT_W'($urandom_range(0, 7));
          dec = COUNT_W'($urandom_range(0, 7));
          sus = COUNT_W'($urandom_range(0, 65536));
          rel = COUNT_W'($urandom_range(0, 7));
        end
        1: begin
          att = '1;
          dec = '1;
          sus = 20'h1_0000;
          rel = '1;
        end
        2: begin
          att = '0;
          dec = '0;
          sus = '0;
          rel = '0;
        end
        3: begin
          att = COUNT_W'($urandom_range(0, 15));
          dec = COUNT_W'($urandom_range(0, 15));
          sus = {3'($urandom_range(0, 7)), 17'($urandom_range(65537, 131071))};
          rel = COUNT_W'($urandom_range(0, 15));
        end
        4: begin
          att = COUNT_W'($urandom_range(0, 63));
          dec = COUNT_W'($urandom_range(0, 63));
          sus = COUNT_W'($urandom_range(0, 65536));
          rel = COUNT_W'($urandom_range(0, 63));
        end
        default: begin
          att = 20'($urandom());
          dec = 20'($urandom());
          sus = 20'($urandom());
          rel = 20'($urandom());
        end
      endcase
      wait_idle();
      write_reg(CFG_ATTACK, att);
      write_reg(CFG_DECAY, dec);
      write_reg(CFG_SUSTAIN, sus);
      write_reg(CFG_RELEASE, rel);
      cfg_we_i <= 1'b0;
      setting_items = 0;
      while (setting_items < ITEMS_PER_SETTING) begin
        // note: gate on, ticks, gate off, ticks
        hold = int'(attack_cfg) + int'(decay_cfg) + 4;
        if (hold > 48) hold = 48;
        tail = int'(release_cfg) + 4;
        if (tail > 24) tail = 24;
        hold = int'($urandom_range(0, hold));
        tail = int'($urandom_range(0, tail));
        feed(OP_GATE_ON);
        repeat (hold) feed(OP_TICK);
        feed(OP_GATE_OFF);
        repeat (tail) feed(OP_TICK);
      end
    end

    // drain and report
    wait_idle();
    if (mismatch_cnt == 0) begin
      $display("linear_adsr_envelope regression: pass");
    end else begin
      $display("linear_adsr_envelope regression: fail");
    end
    $finish;
  end

endmodule
